// ===== rtl/tcs_pkg.sv =====
package tcs_pkg;

    localparam int COLOR_W = 32;
    localparam logic [COLOR_W-1:0] HALF_MASK = 32'd8355711;
    localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd512;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_SHADE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== rtl/tcs_divider.sv =====
module tcs_divider #(
    parameter int VW  = 17,
    parameter int QB  = 6,
    parameter int SBW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [VW+QB-1:0]    dividend,
    input  logic [VW-1:0]       divisor,
    input  logic [SBW-1:0]      in_info,
    output logic                out_valid,
    output logic [QB-1:0]       quotient,
    output logic                overflow,
    output logic [SBW-1:0]      out_info
);

    localparam int DW = VW + QB;

    logic [DW-1:0]  rem_reg  [0:QB];
    logic [DW-1:0]  rem_next [0:QB];
    logic [VW-1:0]  dvs_reg  [0:QB];
    logic [VW-1:0]  dvs_next [0:QB];
    logic [QB-1:0]  quo_reg  [0:QB];
    logic [QB-1:0]  quo_next [0:QB];
    logic [QB:0]    ovf_reg;
    logic [QB:0]    ovf_next;
    logic [SBW-1:0] info_reg  [0:QB];
    logic [SBW-1:0] info_next [0:QB];
    logic [QB:0]    valid_reg;
    logic [QB:0]    valid_next;

    always_comb
    begin
        logic [DW-1:0] trial;
        logic          ge;
        rem_next[0]   = dividend;
        dvs_next[0]   = divisor;
        quo_next[0]   = '0;
        ovf_next[0]   = dividend >= {divisor, {QB{1'b0}}};
        info_next[0]  = in_info;
        valid_next[0] = in_valid;
        for (int i = 0; i < QB; i++)
        begin
            trial           = DW'(dvs_reg[i]) << (QB - 1 - i);
            ge              = rem_reg[i] >= trial;
            rem_next[i+1]   = ge ? (rem_reg[i] - trial) : rem_reg[i];
            dvs_next[i+1]   = dvs_reg[i];
            quo_next[i+1]   = quo_reg[i] | (QB'(ge) << (QB - 1 - i));
            ovf_next[i+1]   = ovf_reg[i];
            info_next[i+1]  = info_reg[i];
            valid_next[i+1] = valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ovf_reg <= ovf_next;
            for (int i = 0; i <= QB; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                dvs_reg[i]  <= dvs_next[i];
                quo_reg[i]  <= quo_next[i];
                info_reg[i] <= info_next[i];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quotient  = quo_reg[QB];
    assign overflow  = ovf_reg[QB];
    assign out_info  = info_reg[QB];

endmodule

// ===== rtl/tcs_texel_mem.sv =====
module tcs_texel_mem import tcs_pkg::*; #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic               clk,
    input  mem_ctl_t           ctl,
    input  logic [AW-1:0]      addr,
    input  logic [COLOR_W-1:0] wr_data,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0] store_mem [0:DEPTH-1];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= store_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/textured_wall_column_shader.sv =====
// Pipeline: a shade item passes through the row divider's registers and then the
//   texel read register before its result is valid; a load item yields no result.
// Throughput: one item per cycle while out_stall does not hold a result, through the row
//   divider (one stage per row bit) and the single-port texel store taking one access per cycle.
// Reset: clears the pipeline valid bits and sets screen_height to 512; the texel
//   store is undefined until loaded and has no clearing pass.
module textured_wall_column_shader import tcs_pkg::*; #(
    parameter int TEX_WIDTH    = 64,
    parameter int TEX_HEIGHT   = 64,
    parameter int SCREEN_WIDTH = 1024,
    parameter int NUM_TILES    = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [10:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic               texture_set,
    input  logic [2:0]         tile_number,
    input  logic [11:0]        texel_index,
    input  logic [31:0]        texel_color,
    input  logic [9:0]         screen_x,
    input  logic [9:0]         screen_y,
    input  logic [15:0]        slice_height,
    input  logic [15:0]        wall_frac,
    input  logic               side,
    input  logic               ray_x_positive,
    input  logic               ray_y_negative,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [19:0]        pixel_index,
    output logic [31:0]        pixel_color
);

    localparam int CW          = $clog2(TEX_WIDTH);
    localparam int QB          = $clog2(TEX_HEIGHT);
    localparam int VW          = 17;
    localparam int DW          = VW + QB;
    localparam int TILE_WORDS  = TEX_WIDTH * TEX_HEIGHT;
    localparam int STORE_WORDS = 2 * NUM_TILES * TILE_WORDS;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int COL_PW      = 16 + $clog2(TEX_WIDTH + 1);
    localparam int PIX_FW      = 22;

    typedef struct packed {
        cmd_t               command;
        logic               texture_set;
        logic [2:0]         tile_number;
        logic [11:0]        texel_index;
        logic [COLOR_W-1:0] texel_color;
        logic [CW-1:0]      col;
        logic               side;
        logic [19:0]        pixel_index;
    } stage_info_t;

    logic [10:0]        sh_reg;
    logic               advance;
    logic               in_acc;
    logic [15:0]        lh_fix;
    logic [18:0]        row_num;
    logic               num_pos;
    logic [DW-1:0]      dividend;
    logic [VW-1:0]      divisor;
    logic [COL_PW-1:0]  col_prod;
    logic [CW-1:0]      col_raw;
    logic               mirror;
    logic [PIX_FW-1:0]  pix_full;
    stage_info_t        in_info;

    logic               dv_valid;
    logic [QB-1:0]      dv_q;
    logic               dv_ovf;
    stage_info_t        dv_info;

    logic [QB-1:0]      row_sel;
    logic               tile_ok;
    logic               texel_ok;
    logic [AW-1:0]      tile_base;
    logic [AW-1:0]      shade_addr;
    logic [AW-1:0]      load_addr;
    logic [AW-1:0]      mem_addr;
    mem_ctl_t           mem_ctl;
    logic [COLOR_W-1:0] rd_data;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic               m_ok_reg;
    logic               m_side_reg;
    logic [19:0]        m_pix_reg;
    logic [COLOR_W-1:0] raw_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            sh_reg <= cfg_wr_data;
        end
    end

    assign advance  = !m_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        lh_fix   = (slice_height == 16'd0) ? 16'd1 : slice_height;
        row_num  = {8'b0, screen_y, 1'b0} + {3'b0, lh_fix} - {8'b0, sh_reg};
        num_pos  = !row_num[18] && (row_num != 19'd0);
        dividend = num_pos ? (DW'(row_num[16:0]) * DW'(TEX_HEIGHT)) : '0;
        divisor  = {lh_fix, 1'b0};
        col_prod = COL_PW'(wall_frac) * COL_PW'(TEX_WIDTH);
        col_raw  = col_prod[16 +: CW];
        mirror   = (!side && ray_x_positive) || (side && ray_y_negative);
        pix_full = PIX_FW'(screen_y) * PIX_FW'(SCREEN_WIDTH) + PIX_FW'(screen_x);

        in_info.command     = cmd_t'(command);
        in_info.texture_set = texture_set;
        in_info.tile_number = tile_number;
        in_info.texel_index = texel_index;
        in_info.texel_color = texel_color;
        in_info.col         = mirror ? (CW'(TEX_WIDTH - 1) - col_raw) : col_raw;
        in_info.side        = side;
        in_info.pixel_index = pix_full[19:0];
    end

    tcs_divider #(
        .VW  (VW),
        .QB  (QB),
        .SBW ($bits(stage_info_t))
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_acc),
        .dividend  (dividend),
        .divisor   (divisor),
        .in_info   (in_info),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .overflow  (dv_ovf),
        .out_info  (dv_info)
    );

    always_comb
    begin
        if (dv_ovf || (dv_q > QB'(TEX_HEIGHT - 1)))
        begin
            row_sel = QB'(TEX_HEIGHT - 1);
        end
        else
        begin
            row_sel = dv_q;
        end
        tile_ok    = 32'(dv_info.tile_number) < NUM_TILES;
        texel_ok   = 32'(dv_info.texel_index) < TILE_WORDS;
        tile_base  = (AW'(dv_info.texture_set) * AW'(NUM_TILES) + AW'(dv_info.tile_number))
                     * AW'(TILE_WORDS);
        shade_addr = tile_base + AW'(row_sel) * AW'(TEX_WIDTH) + AW'(dv_info.col);
        load_addr  = tile_base + AW'(dv_info.texel_index);
        mem_addr   = (dv_info.command == CMD_LOAD) ? load_addr : shade_addr;

        mem_ctl.wr_en = advance && dv_valid && (dv_info.command == CMD_LOAD)
                        && tile_ok && texel_ok;
        mem_ctl.rd_en = advance && dv_valid && (dv_info.command == CMD_SHADE) && tile_ok;
        m_valid_next  = dv_valid && (dv_info.command == CMD_SHADE);
    end

    tcs_texel_mem #(
        .DEPTH (STORE_WORDS),
        .AW    (AW)
    ) u_texel_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (dv_info.texel_color),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_ok_reg   <= tile_ok;
            m_side_reg <= dv_info.side;
            m_pix_reg  <= dv_info.pixel_index;
        end
    end

    // halve the three low channels on y-side hits; the top byte is cleared
    always_comb
    begin
        raw_color   = m_ok_reg ? rd_data : '0;
        pixel_color = m_side_reg ? ((raw_color >> 1) & HALF_MASK) : raw_color;
    end

    assign out_valid   = m_valid_reg;
    assign pixel_index = m_pix_reg;

`ifndef SYNTHESIS
    a_no_access_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> (!mem_ctl.rd_en && !mem_ctl.wr_en))
        else $error("texel store accessed while result held");

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.rd_en |=> out_valid)
        else $error("texel read without result");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> !mem_ctl.rd_en)
        else $error("texel store read and written together");

    a_row_in_texture: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid && (dv_info.command == CMD_SHADE)) |-> (row_sel <= QB'(TEX_HEIGHT - 1)))
        else $error("texture row out of range");
`endif

endmodule
